@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled while reset is high.
`define DDCG_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled while reset is high.
`define DDCG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/ddcg_pkg.sv @@
package ddcg_pkg;

   localparam int ValueWidth  = 27;
   localparam int BinWidth    = 28;
   localparam int BcdWidth    = 32;
   localparam int StepsPerClk = 4;
   localparam int ConvCycles  = BinWidth / StepsPerClk;

   localparam logic [ValueWidth-1:0] FULL_MAX = 27'd99999999;
   localparam logic [ValueWidth-1:0] HALF_MAX = 27'd9999;

   localparam logic [7:0] BASE_RESET = 8'd96;
   localparam logic [3:0] POS_OFFSET = 4'h7;

   typedef enum logic [1:0] {
      OP_FULL  = 2'd0,
      OP_LEFT  = 2'd1,
      OP_RIGHT = 2'd2,
      OP_INIT  = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type           opcode;
      logic [BcdWidth-1:0]  digits;
   } q_entry_type;

   localparam logic [11:0] INIT_WORDS [4] = '{12'h700, 12'h2A0, 12'h401, 12'h580};

   // One double-dabble step: correct every nibble of five or more, then shift in a bit.
   function automatic logic [BcdWidth-1:0] dd_step(input logic [BcdWidth-1:0] bcd,
                                                    input logic bit_in);
      logic [BcdWidth-1:0] adj;
      adj = bcd;
      for (int k = 0; k < BcdWidth / 4; k++) begin
         if (adj[k*4 +: 4] >= 4'd5) begin
            adj[k*4 +: 4] = adj[k*4 +: 4] + 4'd3;
         end
      end
      return {adj[BcdWidth-2:0], bit_in};
   endfunction

   function automatic logic bcd_ok(input logic [BcdWidth-1:0] bcd);
      logic ok;
      ok = 1'b1;
      for (int k = 0; k < BcdWidth / 4; k++) begin
         if (bcd[k*4 +: 4] > 4'd9) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic logic [3:0] n_results(input opcode_type op);
      logic [3:0] n;
      unique case (op) inside
         OP_FULL:            n = 4'd8;
         OP_LEFT, OP_RIGHT:  n = 4'd4;
         default:            n = 4'd12;
      endcase
      return n;
   endfunction

endpackage

@@ sv/decimal_display_command_generator.sv @@
// A digit item is converted to BCD in the front and then queued; an init item skips the conversion.
// The front converts the 28 binary bits four a cycle and takes no new item while converting;
// the back issues one command beat per cycle while the queue is not empty and rsp_ready does not stall it.
// A two-entry queue between front and back lets each stall on its own.
// Reset is synchronous and active high; it empties the queue and sets the base address to 96.
module decimal_display_command_generator
   import ddcg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_opcode,
   input  logic [ValueWidth-1:0]  req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_bus_address,
   output logic [7:0]             rsp_data_byte,
   output logic [11:0]            rsp_command_word,
   output logic                   rsp_last,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data
);

   logic [7:0]   base_ff, base_in;
   logic         q_full, q_push, q_pop, q_empty;
   q_entry_type  q_push_data, q_head;

   assign base_in = csr_wr_en ? csr_wr_data : base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else begin
         base_ff <= base_in;
      end
   end

   ddcg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_value   (req_value),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   ddcg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   ddcg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .base_address     (base_ff),
      .head             (q_head),
      .empty            (q_empty),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bus_address  (rsp_bus_address),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_command_word (rsp_command_word),
      .rsp_last         (rsp_last)
   );

endmodule

@@ sv/ddcg_front.sv @@
`include "assert_macros.svh"

module ddcg_front
   import ddcg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_opcode,
   input  logic [ValueWidth-1:0]  req_value,
   input  logic                   q_full,
   output logic                   q_push,
   output q_entry_type            q_push_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [BinWidth-1:0]    bin_ff, bin_in;
   logic [BcdWidth-1:0]    bcd_ff, bcd_in;
   opcode_type             op_ff, op_in;
   logic                   accept;
   logic [ValueWidth-1:0]  sat_value;

   assign q_push      = (state_ff == ST_DONE) && !q_full;
   assign req_ready   = (state_ff == ST_IDLE) || q_push;
   assign accept      = req_valid && req_ready;
   assign q_push_data = '{opcode: op_ff, digits: bcd_ff};

   always_comb begin
      unique case (opcode_type'(req_opcode)) inside
         OP_FULL:           sat_value = (req_value > FULL_MAX) ? FULL_MAX : req_value;
         OP_LEFT, OP_RIGHT: sat_value = (req_value > HALF_MAX) ? HALF_MAX : req_value;
         default:           sat_value = '0;
      endcase
   end

   always_comb begin
      logic [BcdWidth-1:0] t_bcd;
      logic [BinWidth-1:0] t_bin;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      op_in    = op_ff;
      t_bcd    = bcd_ff;
      t_bin    = bin_ff;
      unique case (state_ff)
         ST_CONV: begin
            for (int i = 0; i < StepsPerClk; i++) begin
               t_bcd = dd_step(t_bcd, t_bin[BinWidth-1]);
               t_bin = {t_bin[BinWidth-2:0], 1'b0};
            end
            bcd_in = t_bcd;
            bin_in = t_bin;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'(ConvCycles - 1)) begin
               state_in = ST_DONE;
            end
         end
         default: begin
            if (q_push) begin
               state_in = ST_IDLE;
            end
            if (accept) begin
               op_in  = opcode_type'(req_opcode);
               bin_in = {1'b0, sat_value};
               bcd_in = '0;
               cnt_in = '0;
               // The init sequence shows zeros, so there is nothing to convert.
               state_in = (opcode_type'(req_opcode) == OP_INIT) ? ST_DONE : ST_CONV;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      op_ff  <= op_in;
   end

   `DDCG_ASSERT_IMP(a_done_is_bcd, state_ff == ST_DONE, bcd_ok(bcd_ff), "non-decimal digit")
   `DDCG_ASSERT_IMP(a_cnt_bound, state_ff == ST_CONV, cnt_ff < 3'(ConvCycles), "count overrun")
   `DDCG_ASSERT_NEXT(a_init_direct, accept && req_opcode == OP_INIT,
                     state_ff == ST_DONE && bcd_ff == '0, "init beat not queued as zeros")

endmodule

@@ sv/ddcg_queue.sv @@
module ddcg_queue
   import ddcg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  q_entry_type  push_data,
   output logic         full,
   input  logic         pop,
   output q_entry_type  head,
   output logic         empty
);

   q_entry_type  mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/ddcg_back.sv @@
`include "assert_macros.svh"

module ddcg_back
   import ddcg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   base_address,
   input  q_entry_type  head,
   input  logic         empty,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [7:0]   rsp_bus_address,
   output logic [7:0]   rsp_data_byte,
   output logic [11:0]  rsp_command_word,
   output logic         rsp_last
);

   logic [3:0]   idx_ff, idx_in;
   logic         valid_ff, valid_in;
   logic [7:0]   addr_ff, addr_in;
   logic [11:0]  word_ff, word_in;
   logic         last_ff, last_in;
   logic         load, issue, is_last;
   logic [11:0]  word;
   logic [3:0]   pos;
   logic [3:0]   digit;
   logic [2:0]   sel8;
   logic [1:0]   sel4;

   assign load    = !valid_ff || rsp_ready;
   assign issue   = load && !empty;
   assign is_last = (idx_ff == n_results(head.opcode) - 4'd1);
   assign pop     = issue && is_last;
   assign sel8    = 3'd7 - idx_ff[2:0];
   assign sel4    = 2'd3 - idx_ff[1:0];

   always_comb begin
      unique case (head.opcode)
         OP_FULL: begin
            pos   = idx_ff + 4'd1;
            digit = head.digits[{sel8, 2'b00} +: 4];
         end
         OP_LEFT: begin
            pos   = idx_ff + 4'd1;
            digit = head.digits[{1'b0, sel4, 2'b00} +: 4];
         end
         OP_RIGHT: begin
            pos   = idx_ff + 4'd5;
            digit = head.digits[{1'b0, sel4, 2'b00} +: 4];
         end
         default: begin
            pos   = idx_ff - 4'd3;
            digit = 4'd0;
         end
      endcase
      // The first four beats of the init sequence are the fixed set-up words.
      if (head.opcode == OP_INIT && idx_ff < 4'd4) begin
         word = INIT_WORDS[idx_ff[1:0]];
      end else begin
         word = {pos + POS_OFFSET, 4'h0, digit};
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      addr_in  = addr_ff;
      word_in  = word_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = !empty;
      end
      if (issue) begin
         addr_in = base_address + {3'b000, word[11:7]};
         word_in = word;
         last_in = is_last;
         idx_in  = is_last ? 4'd0 : idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      addr_ff <= addr_in;
      word_ff <= word_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_bus_address  = addr_ff;
   assign rsp_data_byte    = word_ff[7:0];
   assign rsp_command_word = word_ff;
   assign rsp_last         = last_ff;

   `DDCG_ASSERT_IMP(a_idx_bound, !empty, idx_ff < n_results(head.opcode), "beat index overrun")
   `DDCG_ASSERT_NEXT(a_idx_wrap, pop, idx_ff == 4'd0, "index not cleared after final beat")
   `DDCG_ASSERT_IMP(a_digit_word, valid_ff && word_ff[11:8] >= 4'd8,
                    word_ff[7:4] == 4'd0 && word_ff[3:0] <= 4'd9, "malformed digit command")

endmodule
